### design/lr_pkg.sv
// ----------------------------------------------------------------------------
// lr_pkg: shared types and constants of the line rasteriser
// Coordinate widths, register indexes, command codes and the structs that
// pass between the front end, the command queue and the drawing engine.
// ----------------------------------------------------------------------------
package lr_pkg;

    // coordinate and derived widths
    localparam int COORD_BITS  = 10;
    localparam int DIM_W       = COORD_BITS + 1;
    localparam int ADDR_W      = 2 * COORD_BITS;
    localparam int COLOUR_W    = 8;
    localparam int ERR_W       = COORD_BITS + 3;
    localparam int E2_W        = ERR_W + 1;
    localparam int PROD_W      = COORD_BITS + DIM_W;
    localparam int CFG_IDX_W   = 2;

    // command queue geometry
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [DIM_W-1:0]      dim_t;
    typedef logic [ADDR_W-1:0]     addr_t;
    typedef logic [COLOUR_W-1:0]   colour_t;
    typedef logic signed [ERR_W-1:0] err_t;

    // register reset values
    localparam dim_t WIDTH_RESET  = DIM_W'(320);
    localparam dim_t HEIGHT_RESET = DIM_W'(240);

    // command codes
    typedef enum logic
    {
        OP_START = 1'b0,
        OP_TICK  = 1'b1
    } op_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_BITMAP_WIDTH  = 2'd0,
        REG_BITMAP_HEIGHT = 2'd1,
        REG_STEP_MODE     = 2'd2
    } cfg_reg_t;

    // classified command as held in the queue
    typedef struct packed
    {
        op_t     op;
        coord_t  start_x;
        coord_t  start_y;
        coord_t  end_x;
        coord_t  end_y;
        colour_t colour;
        err_t    delta_x;
        err_t    neg_delta_y;
        logic    dir_x_neg;
        logic    dir_y_neg;
    } lr_cmd_t;

    // engine status seen by the top level
    typedef struct packed
    {
        logic busy;
        logic pix_pending;
    } lr_status_t;

endpackage

### design/lr_intf.sv
// ----------------------------------------------------------------------------
// lr_intf: channel interfaces of the line rasteriser
// Command channel, pixel channel and configuration write channel, each a
// valid/ready handshake with a source and a sink modport.
// ----------------------------------------------------------------------------
interface lr_cmd_if import lr_pkg::*; ();
    logic    valid;
    logic    ready;
    logic    op;
    coord_t  start_x;
    coord_t  start_y;
    coord_t  end_x;
    coord_t  end_y;
    colour_t line_colour;

    modport source (output valid, output op, output start_x, output start_y,
                    output end_x, output end_y, output line_colour, input ready);
    modport sink   (input valid, input op, input start_x, input start_y,
                    input end_x, input end_y, input line_colour, output ready);
endinterface

interface lr_pix_if import lr_pkg::*; ();
    logic    valid;
    logic    ready;
    coord_t  dst_col;
    coord_t  dst_row;
    addr_t   pixel_address;
    colour_t pixel_value;
    logic    in_bounds;
    logic    last_pixel;

    modport source (output valid, output dst_col, output dst_row,
                    output pixel_address, output pixel_value, output in_bounds,
                    output last_pixel, input ready);
    modport sink   (input valid, input dst_col, input dst_row,
                    input pixel_address, input pixel_value, input in_bounds,
                    input last_pixel, output ready);
endinterface

interface lr_cfg_if import lr_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    dim_t                 data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### design/line_rasterizer.sv
// ----------------------------------------------------------------------------
// line_rasterizer: Bresenham line generator for a blitter
// Start beats load a line, tick beats on an active line each give one pixel write beat.
// ----------------------------------------------------------------------------
// A start beat loads both endpoints and a colour and gives no pixel; a later
// start replaces a line still in progress. Each tick beat while a line is
// active gives one pixel beat (column, flipped row, linear address, colour,
// in-bounds flag, last flag on the far endpoint); a tick with no active line
// is swallowed. The engine takes one command a cycle unless the pixel channel
// stalls it, so ticks sent back to back give one pixel per clock; that rate
// is set by the Bresenham step register loop in the engine. A tick passes the
// front register, the queue, the pixel stage and the address multiply into
// the output register before its pixel beat is presented. Configuration
// registers are taken at any time and must be written only while no command
// or pixel is in flight.
// ----------------------------------------------------------------------------
module line_rasterizer import lr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    lr_cmd_if.sink   cmd,
    lr_pix_if.source pix,
    lr_cfg_if.sink   cfg
);

    dim_t       width_reg;
    dim_t       height_reg;
    logic       mode_reg;
    lr_cmd_t    f_entry;
    logic       f_valid;
    logic       f_ready;
    lr_cmd_t    q_entry;
    logic       q_valid;
    logic       q_ready;
    lr_status_t eng_status;

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            mode_reg   <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_BITMAP_WIDTH:  width_reg  <= cfg.data;
                REG_BITMAP_HEIGHT: height_reg <= cfg.data;
                REG_STEP_MODE:     mode_reg   <= cfg.data[0];
                default:           ;
            endcase
        end
    end

    // command front end
    lr_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .q_entry (f_entry),
        .q_valid (f_valid),
        .q_ready (f_ready)
    );

    // command queue
    lr_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_entry (f_entry),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .pop_entry  (q_entry),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready)
    );

    // drawing engine
    lr_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_entry       (q_entry),
        .q_valid       (q_valid),
        .q_ready       (q_ready),
        .bitmap_width  (width_reg),
        .bitmap_height (height_reg),
        .step_mode     (mode_reg),
        .pix           (pix),
        .status        (eng_status)
    );

`ifndef SYNTHESIS
    // a start taken by the engine always leaves a line active
    a_start_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && q_ready && (q_entry.op == OP_START)) |=> eng_status.busy)
        else $error("start command did not activate the engine");

    // a tick with no active line makes no pixel
    a_idle_tick_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && q_ready && (q_entry.op == OP_TICK) && !eng_status.busy)
        |=> !eng_status.pix_pending)
        else $error("idle tick produced a pixel");

    // a tick on an active line always makes a pixel
    a_busy_tick_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && q_ready && (q_entry.op == OP_TICK) && eng_status.busy)
        |=> eng_status.pix_pending)
        else $error("busy tick lost its pixel");
`endif

endmodule

### design/lr_front.sv
// ----------------------------------------------------------------------------
// lr_front: command front end
// Takes command beats, works out the line deltas and directions for a start
// and registers the classified command for the queue.
// ----------------------------------------------------------------------------
module lr_front import lr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    lr_cmd_if.sink    cmd,
    output lr_cmd_t   q_entry,
    output logic      q_valid,
    input  logic      q_ready
);

    logic    valid_reg;
    lr_cmd_t entry_reg;
    lr_cmd_t entry_next;
    coord_t  abs_dx;
    coord_t  abs_dy;
    err_t    dx_ext;
    err_t    dy_ext;

    // stage takes a beat when empty or when the queue takes its content
    assign cmd.ready = !valid_reg || q_ready;

    // absolute deltas and directions
    always_comb
    begin
        abs_dx = (cmd.end_x >= cmd.start_x) ? (cmd.end_x - cmd.start_x)
                                            : (cmd.start_x - cmd.end_x);
        abs_dy = (cmd.end_y >= cmd.start_y) ? (cmd.end_y - cmd.start_y)
                                            : (cmd.start_y - cmd.end_y);
        dx_ext = $signed({{(ERR_W-COORD_BITS){1'b0}}, abs_dx});
        dy_ext = $signed({{(ERR_W-COORD_BITS){1'b0}}, abs_dy});

        entry_next.op          = op_t'(cmd.op);
        entry_next.start_x     = cmd.start_x;
        entry_next.start_y     = cmd.start_y;
        entry_next.end_x       = cmd.end_x;
        entry_next.end_y       = cmd.end_y;
        entry_next.colour      = cmd.line_colour;
        entry_next.delta_x     = dx_ext;
        entry_next.neg_delta_y = -dy_ext;
        entry_next.dir_x_neg   = !(cmd.start_x < cmd.end_x);
        entry_next.dir_y_neg   = !(cmd.start_y < cmd.end_y);
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            valid_reg <= cmd.valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            entry_reg <= entry_next;
        end
    end

    assign q_valid = valid_reg;
    assign q_entry = entry_reg;

endmodule

### design/lr_queue.sv
// ----------------------------------------------------------------------------
// lr_queue: command queue
// Short first-in first-out buffer between the front end and the engine so
// that either side can stall without holding up the other.
// ----------------------------------------------------------------------------
module lr_queue import lr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  lr_cmd_t push_entry,
    input  logic    push_valid,
    output logic    push_ready,
    output lr_cmd_t pop_entry,
    output logic    pop_valid,
    input  logic    pop_ready
);

    lr_cmd_t            store_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic               push;
    logic               pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_entry  = store_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

### design/lr_back.sv
// ----------------------------------------------------------------------------
// lr_back: line drawing engine
// Holds the current line, takes one command a cycle from the queue unless
// stalled, makes one Bresenham step per busy tick and forms the pixel beat
// in two stages (flip and bounds; address multiply into the output register).
// ----------------------------------------------------------------------------
module lr_back import lr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  lr_cmd_t    q_entry,
    input  logic       q_valid,
    output logic       q_ready,
    input  dim_t       bitmap_width,
    input  dim_t       bitmap_height,
    input  logic       step_mode,
    lr_pix_if.source   pix,
    output lr_status_t status
);

    // line state
    logic    busy_reg;
    coord_t  cur_x_reg;
    coord_t  cur_y_reg;
    coord_t  tgt_x_reg;
    coord_t  tgt_y_reg;
    err_t    dx_reg;
    err_t    ndy_reg;
    err_t    err_reg;
    logic    dxn_reg;
    logic    dyn_reg;
    colour_t colour_reg;

    // pixel stage
    logic    s1_valid_reg;
    coord_t  s1_col_reg;
    coord_t  s1_row_reg;
    colour_t s1_colour_reg;
    logic    s1_inb_reg;
    logic    s1_last_reg;

    // output register
    logic    o_valid_reg;
    coord_t  o_col_reg;
    coord_t  o_row_reg;
    addr_t   o_addr_reg;
    colour_t o_colour_reg;
    logic    o_inb_reg;
    logic    o_last_reg;

    logic                 o_free;
    logic                 s1_free;
    logic                 pop;
    logic                 do_start;
    logic                 emit;
    logic                 at_end;
    logic                 inb;
    dim_t                 height_m1;
    dim_t                 row_full;
    logic signed [E2_W-1:0] e2;
    logic                 x_ok;
    logic                 y_ok;
    logic                 step_x;
    logic                 step_y;
    err_t                 err_next;
    coord_t               x_next;
    coord_t               y_next;
    logic [PROD_W-1:0]    addr_full;

    // handshake between the stages
    assign o_free   = !o_valid_reg || pix.ready;
    assign s1_free  = !s1_valid_reg || o_free;
    assign q_ready  = s1_free;
    assign pop      = q_valid && s1_free;
    assign do_start = pop && (q_entry.op == OP_START);
    assign emit     = pop && (q_entry.op == OP_TICK) && busy_reg;

    // current pixel: flip, bounds and endpoint
    always_comb
    begin
        height_m1 = bitmap_height - DIM_W'(1);
        row_full  = height_m1 - {1'b0, cur_y_reg};
        inb       = ({1'b0, cur_x_reg} < bitmap_width) && ({1'b0, cur_y_reg} < bitmap_height);
        at_end    = (cur_x_reg == tgt_x_reg) && (cur_y_reg == tgt_y_reg);
    end

    // one Bresenham step
    always_comb
    begin
        e2       = $signed({err_reg, 1'b0});
        x_ok     = e2 >= $signed({ndy_reg[ERR_W-1], ndy_reg});
        y_ok     = e2 <= $signed({dx_reg[ERR_W-1], dx_reg});
        step_x   = x_ok;
        step_y   = x_ok ? (!step_mode && y_ok) : y_ok;
        err_next = err_reg + (step_x ? ndy_reg : '0) + (step_y ? dx_reg : '0);
        x_next   = step_x ? (dxn_reg ? cur_x_reg - COORD_BITS'(1) : cur_x_reg + COORD_BITS'(1))
                          : cur_x_reg;
        y_next   = step_y ? (dyn_reg ? cur_y_reg - COORD_BITS'(1) : cur_y_reg + COORD_BITS'(1))
                          : cur_y_reg;
    end

    // busy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (do_start)
        begin
            busy_reg <= 1'b1;
        end
        else if (emit && at_end)
        begin
            busy_reg <= 1'b0;
        end
    end

    // line registers, loaded on start and advanced on each busy tick
    always_ff @(posedge clk)
    begin
        if (do_start)
        begin
            cur_x_reg  <= q_entry.start_x;
            cur_y_reg  <= q_entry.start_y;
            tgt_x_reg  <= q_entry.end_x;
            tgt_y_reg  <= q_entry.end_y;
            dx_reg     <= q_entry.delta_x;
            ndy_reg    <= q_entry.neg_delta_y;
            err_reg    <= q_entry.delta_x + q_entry.neg_delta_y;
            dxn_reg    <= q_entry.dir_x_neg;
            dyn_reg    <= q_entry.dir_y_neg;
            colour_reg <= q_entry.colour;
        end
        else if (emit && !at_end)
        begin
            cur_x_reg <= x_next;
            cur_y_reg <= y_next;
            err_reg   <= err_next;
        end
    end

    // stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= emit;
            end
            if (o_free)
            begin
                o_valid_reg <= s1_valid_reg;
            end
        end
    end

    // pixel stage payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            s1_col_reg    <= cur_x_reg;
            s1_row_reg    <= row_full[COORD_BITS-1:0];
            s1_colour_reg <= colour_reg;
            s1_inb_reg    <= inb;
            s1_last_reg   <= at_end;
        end
    end

    // linear address
    assign addr_full = PROD_W'(s1_row_reg) * PROD_W'(bitmap_width) + PROD_W'(s1_col_reg);

    // output register payload
    always_ff @(posedge clk)
    begin
        if (o_free && s1_valid_reg)
        begin
            o_col_reg    <= s1_col_reg;
            o_row_reg    <= s1_row_reg;
            o_addr_reg   <= addr_full[ADDR_W-1:0];
            o_colour_reg <= s1_colour_reg;
            o_inb_reg    <= s1_inb_reg;
            o_last_reg   <= s1_last_reg;
        end
    end

    assign pix.valid         = o_valid_reg;
    assign pix.dst_col       = o_col_reg;
    assign pix.dst_row       = o_row_reg;
    assign pix.pixel_address = o_addr_reg;
    assign pix.pixel_value   = o_colour_reg;
    assign pix.in_bounds     = o_inb_reg;
    assign pix.last_pixel    = o_last_reg;

    assign status.busy        = busy_reg;
    assign status.pix_pending = s1_valid_reg;

endmodule
